@@ src/rpag_pkg.sv @@
// shared types, constants and glyph table for the rgb pixel to ascii glyph color unit
package rpag_pkg;

  // field widths
  localparam int CHAN_W   = 8;
  localparam int HNOISE_W = 7;
  localparam int LNOISE_W = 5;
  localparam int GLYPH_W  = 7;
  localparam int SLOT_W   = 3;

  // internal widths
  localparam int DIFF_W   = CHAN_W + 1;        // signed channel difference
  localparam int SUM_W    = CHAN_W + 3;        // signed channel sum plus luma noise
  localparam int MULT_W   = CHAN_W + 3;        // up to six times delta
  localparam int NUM_W    = MULT_W + 1;        // signed hue numerator
  localparam int BOUND_W  = 2 * CHAN_W + 1;    // (threshold + 1) * max
  localparam int IDX_W    = 4;

  // hue sectors and glyph ramp
  localparam int SECTOR_MAX = 6;
  localparam int RAMP_LAST  = 10;
  localparam int LUMA_STEP  = 3 * 25;          // two truncating divisions fold into one

  // which channel holds the maximum
  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  // one input pixel with its noise values
  typedef struct packed {
    logic [CHAN_W-1:0]          red;
    logic [CHAN_W-1:0]          green;
    logic [CHAN_W-1:0]          blue;
    logic [CHAN_W-1:0]          sat_noise;
    logic signed [HNOISE_W-1:0] hue_noise;
    logic [CHAN_W-1:0]          light_noise;
    logic signed [LNOISE_W-1:0] luma_noise;
  } pix_t;

  // after channel extraction
  typedef struct packed {
    logic [CHAN_W-1:0]          mx;
    logic [CHAN_W-1:0]          delta;
    max_sel_t                   sel;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [HNOISE_W-1:0] hue_noise;
    logic [CHAN_W-1:0]          sat_noise;
    logic [CHAN_W-1:0]          light_noise;
    logic signed [SUM_W-1:0]    luma_sum;
  } s1_t;

  // after scaling
  typedef struct packed {
    logic [CHAN_W-1:0]                    delta;
    logic [BOUND_W-1:0]                   sat_bound;
    logic signed [NUM_W-1:0]              num;
    logic [SECTOR_MAX-1:0][MULT_W-1:0]    mult;
    logic                                 light;
    logic [GLYPH_W-1:0]                   glyph_code;
  } s2_t;

  // one result item
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_code;
    logic               colored;
    logic [SLOT_W-1:0]  hue_slot;
    logic               light;
  } res_t;

  // ascii ramp " .:;=%$W#8@"
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [IDX_W-1:0] idx);
    logic [GLYPH_W-1:0] code;
    case (idx)
      4'd0:    code = 7'd32;
      4'd1:    code = 7'd46;
      4'd2:    code = 7'd58;
      4'd3:    code = 7'd59;
      4'd4:    code = 7'd61;
      4'd5:    code = 7'd37;
      4'd6:    code = 7'd36;
      4'd7:    code = 7'd87;
      4'd8:    code = 7'd35;
      4'd9:    code = 7'd56;
      default: code = 7'd64;
    endcase
    return code;
  endfunction

endpackage

@@ src/rgb_pixel_to_ascii_glyph_color_unit.sv @@
// top level of the rgb pixel to ascii glyph color unit
//
// Maps one RGB pixel plus four dither noise values to an ascii glyph code,
// a colored/gray flag, a hue sector 0..6 and a light/dark shade.
// Input channel: pixel_valid / pixel_stall with red, green, blue and the
// noise fields; an item is taken at a clock edge with valid high and stall low.
// Output channel: glyph_valid / glyph_stall with glyph_code, colored,
// hue_slot and light.
// Throughput is one item per cycle while the receiver does not stall, through
// a three stage pipeline (extract, scale, decide), each stage with its own
// valid bit.
// When the receiver stalls, the output register holds its item and earlier
// stages keep filling until every stage is occupied; only then is
// pixel_stall raised, so bubbles are squeezed out and nothing is lost.
// Synchronous reset clears all valid bits; the block keeps no state between
// pixels, so it is ready for a new item in the cycle after reset.
module rgb_pixel_to_ascii_glyph_color_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [rpag_pkg::CHAN_W-1:0]          red,
  input  logic [rpag_pkg::CHAN_W-1:0]          green,
  input  logic [rpag_pkg::CHAN_W-1:0]          blue,
  input  logic [rpag_pkg::CHAN_W-1:0]          sat_noise,
  input  logic signed [rpag_pkg::HNOISE_W-1:0] hue_noise,
  input  logic [rpag_pkg::CHAN_W-1:0]          light_noise,
  input  logic signed [rpag_pkg::LNOISE_W-1:0] luma_noise,
  output logic                                glyph_valid,
  input  logic                                glyph_stall,
  output logic [rpag_pkg::GLYPH_W-1:0]         glyph_code,
  output logic                                colored,
  output logic [rpag_pkg::SLOT_W-1:0]          hue_slot,
  output logic                                light
);

  rpag_pkg::pix_t pix;
  rpag_pkg::s1_t  s1;
  rpag_pkg::s2_t  s2;
  rpag_pkg::res_t res;

  logic s1_valid, s2_valid, out_valid;
  logic s1_valid_next, s2_valid_next, out_valid_next;
  logic adv1, adv2, adv3;
  logic load1, load2, load3;

  // stage advance: a stage may load when empty or when its item moves on
  assign adv3  = !out_valid || !glyph_stall;
  assign adv2  = !s2_valid || adv3;
  assign adv1  = !s1_valid || adv2;
  assign load1 = pixel_valid && adv1;
  assign load2 = s1_valid && adv2;
  assign load3 = s2_valid && adv3;

  assign pixel_stall = !adv1;

  // valid bits travel with the data
  always_comb begin
    s1_valid_next  = load1 || (s1_valid && !adv2);
    s2_valid_next  = load2 || (s2_valid && !adv3);
    out_valid_next = load3 || (out_valid && glyph_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      s2_valid  <= s2_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // input item
  always_comb begin
    pix.red         = red;
    pix.green       = green;
    pix.blue        = blue;
    pix.sat_noise   = sat_noise;
    pix.hue_noise   = hue_noise;
    pix.light_noise = light_noise;
    pix.luma_noise  = luma_noise;
  end

  rpag_extract u_extract (
    .clk  (clk),
    .load (load1),
    .pix  (pix),
    .s1   (s1)
  );

  rpag_scale u_scale (
    .clk  (clk),
    .load (load2),
    .s1   (s1),
    .s2   (s2)
  );

  rpag_decide u_decide (
    .clk  (clk),
    .load (load3),
    .s2   (s2),
    .res  (res)
  );

  // result item
  assign glyph_valid = out_valid;
  assign glyph_code  = res.glyph_code;
  assign colored     = res.colored;
  assign hue_slot    = res.hue_slot;
  assign light       = res.light;

endmodule

@@ src/rpag_extract.sv @@
// first stage: channel min, max, delta, hue difference and luma sum
module rpag_extract (
  input  logic          clk,
  input  logic          load,
  input  rpag_pkg::pix_t pix,
  output rpag_pkg::s1_t  s1
);

  logic [rpag_pkg::CHAN_W-1:0] mn;
  logic [rpag_pkg::CHAN_W-1:0] mx;
  rpag_pkg::s1_t               s1_next;

  // min and max of the three channels
  always_comb begin
    mn = pix.red;
    mx = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    if (pix.blue > mx) mx = pix.blue;
  end

  // pick the max channel and the cyclic difference of the other two
  always_comb begin
    s1_next.mx          = mx;
    s1_next.delta       = mx - mn;
    s1_next.hue_noise   = pix.hue_noise;
    s1_next.sat_noise   = pix.sat_noise;
    s1_next.light_noise = pix.light_noise;
    s1_next.luma_sum    = $signed({3'b000, pix.red}) + $signed({3'b000, pix.green})
                        + $signed({3'b000, pix.blue})
                        + rpag_pkg::SUM_W'(pix.luma_noise);
    if (pix.red == mx) begin
      s1_next.sel  = rpag_pkg::MAX_RED;
      s1_next.diff = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
    end else if (pix.green == mx) begin
      s1_next.sel  = rpag_pkg::MAX_GREEN;
      s1_next.diff = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
    end else begin
      s1_next.sel  = rpag_pkg::MAX_BLUE;
      s1_next.diff = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= s1_next;
    end
  end

endmodule

@@ src/rpag_scale.sv @@
// second stage: saturation bound, hue numerator, delta multiples, shade test, glyph lookup
module rpag_scale (
  input  logic          clk,
  input  logic          load,
  input  rpag_pkg::s1_t  s1,
  output rpag_pkg::s2_t  s2
);

  logic [rpag_pkg::MULT_W-1:0]  d1;
  logic [rpag_pkg::MULT_W-1:0]  d3;
  logic [rpag_pkg::MULT_W-1:0]  d5;
  logic [rpag_pkg::MULT_W-1:0]  base_d;
  logic [rpag_pkg::IDX_W-1:0]   idx;
  rpag_pkg::s2_t                s2_next;

  // small multiples of delta by shift and add
  assign d1 = rpag_pkg::MULT_W'(s1.delta);
  assign d3 = (d1 << 1) + d1;
  assign d5 = (d1 << 2) + d1;

  always_comb begin
    case (s1.sel)
      rpag_pkg::MAX_RED:   base_d = d1;
      rpag_pkg::MAX_GREEN: base_d = d3;
      rpag_pkg::MAX_BLUE:  base_d = d5;
      default:             base_d = d1;
    endcase
  end

  // brightness index: count of ramp steps the luma sum reaches
  always_comb begin
    idx = '0;
    for (int k = 1; k <= rpag_pkg::RAMP_LAST; k++) begin
      if (s1.luma_sum >= $signed(rpag_pkg::SUM_W'(k * rpag_pkg::LUMA_STEP))) begin
        idx = idx + 1'b1;
      end
    end
  end

  // stage result
  always_comb begin
    s2_next.delta      = s1.delta;
    s2_next.sat_bound  = (rpag_pkg::BOUND_W'(s1.sat_noise) + rpag_pkg::BOUND_W'(1))
                       * rpag_pkg::BOUND_W'(s1.mx);
    s2_next.num        = $signed({1'b0, base_d}) + rpag_pkg::NUM_W'(s1.diff)
                       + $signed({1'b0, d1 >> 1}) + rpag_pkg::NUM_W'(s1.hue_noise);
    s2_next.mult[0]    = d1;
    s2_next.mult[1]    = d1 << 1;
    s2_next.mult[2]    = d3;
    s2_next.mult[3]    = d1 << 2;
    s2_next.mult[4]    = d5;
    s2_next.mult[5]    = d3 << 1;
    s2_next.light      = (s1.mx > s1.light_noise);
    s2_next.glyph_code = rpag_pkg::glyph_of(idx);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2 <= s2_next;
    end
  end

endmodule

@@ src/rpag_decide.sv @@
// third stage: colored test, hue sector count and output register
module rpag_decide (
  input  logic          clk,
  input  logic          load,
  input  rpag_pkg::s2_t  s2,
  output rpag_pkg::res_t res
);

  logic                          colored;
  logic [rpag_pkg::SLOT_W-1:0]   sector;
  rpag_pkg::res_t                res_next;

  // saturation above threshold, i.e. 256*delta >= (threshold+1)*max
  assign colored = (s2.delta != '0)
                && ({1'b0, s2.delta, 8'h00} >= s2.sat_bound);

  // sector is the number of delta multiples the numerator reaches, at most six
  always_comb begin
    sector = '0;
    for (int k = 0; k < rpag_pkg::SECTOR_MAX; k++) begin
      if (s2.num >= $signed({1'b0, s2.mult[k]})) begin
        sector = sector + 1'b1;
      end
    end
  end

  // gray pixels carry no hue and no shade
  always_comb begin
    res_next.glyph_code = s2.glyph_code;
    res_next.colored    = colored;
    res_next.hue_slot   = colored ? sector : '0;
    res_next.light      = colored & s2.light;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

@@ src/rpag_checker.sv @@
// port-level checker for the rgb pixel to ascii glyph color unit, with its bind
module rpag_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        glyph_valid,
  input logic                        glyph_stall,
  input logic [rpag_pkg::GLYPH_W-1:0] glyph_code,
  input logic                        colored,
  input logic [rpag_pkg::SLOT_W-1:0]  hue_slot,
  input logic                        light
);

  // no item comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !glyph_valid)
    else $error("result item shown right after reset");

  // gray items carry no hue sector and no shade
  a_gray_fields: assert property (@(posedge clk) disable iff (rst)
    (glyph_valid && !colored) |-> (hue_slot == '0 && !light))
    else $error("gray item with hue or shade set");

  // hue sector stays in the range 0 to SECTOR_MAX
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    glyph_valid |-> (hue_slot <= 3'(rpag_pkg::SECTOR_MAX)))
    else $error("hue sector out of range");

  // a stalled item stays and keeps its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (glyph_valid && glyph_stall) |=> (glyph_valid && $stable(glyph_code)
      && $stable(colored) && $stable(hue_slot) && $stable(light)))
    else $error("stalled result item changed or dropped");

endmodule

bind rgb_pixel_to_ascii_glyph_color_unit rpag_checker u_rpag_checker (
  .clk         (clk),
  .rst         (rst),
  .glyph_valid (glyph_valid),
  .glyph_stall (glyph_stall),
  .glyph_code  (glyph_code),
  .colored     (colored),
  .hue_slot    (hue_slot),
  .light       (light)
);
